// File: rtl/core/assert_macros.svh
// Assertion macros shared by the transaction core modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define ASSERT_HOLDS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/mdb_mt_pkg.sv
// Types, codes and helper functions of the bus master transaction core.
`default_nettype none

package mdb_mt_pkg;

    localparam int FRAME_BYTES = 36;
    localparam int REPLY_DEPTH = 36;
    localparam int SENT_W      = $clog2(FRAME_BYTES + 1);
    localparam int RCNT_W      = $clog2(REPLY_DEPTH + 1);
    localparam int RAM_AW      = $clog2(REPLY_DEPTH);
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;

    localparam logic [15:0] TIMEOUT_RESET = 16'd50;
    localparam logic [15:0] TIMER_MAX     = 16'hFFFF;

    localparam logic [CFG_IDX_W-1:0] CFG_MASTER_ENABLE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 1'd1;

    localparam logic [1:0] ACT_FRAME = 2'd0;
    localparam logic [1:0] ACT_BUS   = 2'd1;
    localparam logic [1:0] ACT_TICK  = 2'd2;

    localparam logic [1:0] KIND_TX     = 2'd0;
    localparam logic [1:0] KIND_DATA   = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    localparam logic [2:0] ST_ACK        = 3'd0;
    localparam logic [2:0] ST_NAK        = 3'd1;
    localparam logic [2:0] ST_RET        = 3'd2;
    localparam logic [2:0] ST_TIMEOUT    = 3'd3;
    localparam logic [2:0] ST_CHECKSUM   = 3'd4;
    localparam logic [2:0] ST_OVERFLOW   = 3'd5;
    localparam logic [2:0] ST_DONE       = 3'd6;
    localparam logic [2:0] ST_NOT_MASTER = 3'd7;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_SEND = 2'd1;
    localparam logic [1:0] PH_WAIT = 2'd2;

    localparam logic       MODE_BIT = 1'b1;
    localparam logic [7:0] WORD_ACK = 8'h00;
    localparam logic [7:0] WORD_NAK = 8'hFF;
    localparam logic [7:0] WORD_RET = 8'hAA;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] frame_byte;
        logic       frame_last;
        logic [8:0] rx_word;
    } t_in_word;

    typedef struct packed {
        logic [1:0] kind;
        logic [8:0] tx_word;
        logic [7:0] host_byte;
        logic [2:0] status;
        logic       last;
    } t_out_word;

    typedef struct packed {
        logic process;
        logic rd;
        logic rd_next;
        logic ld_data;
        logic ld_tail0;
        logic ld_tail1;
    } t_cmd;

    typedef struct packed {
        logic slot_free;
        logic nd_zero;
        logic idx_last;
        logic tail0_v;
        logic tail1_v;
    } t_sts;

    function automatic t_out_word f_tx(input logic [8:0] word);
        t_out_word r;
        r         = '0;
        r.kind    = KIND_TX;
        r.tx_word = word;
        return r;
    endfunction

    function automatic t_out_word f_status(input logic [2:0] code);
        t_out_word r;
        r        = '0;
        r.kind   = KIND_STATUS;
        r.status = code;
        return r;
    endfunction

    function automatic t_out_word f_data(input logic [7:0] data);
        t_out_word r;
        r           = '0;
        r.kind      = KIND_DATA;
        r.host_byte = data;
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/mdb_master_transaction_core.sv
// Top level of the multi-drop bus master transaction core.
// Input channel: one word per action (host frame byte, received bus word or
// timer tick), accepted when i_in_valid and o_in_ready are both high.
// Output channel: result words of kind bus transmit word, reply data byte or
// status, with last set on the final result caused by an input word.
// Configuration channel: master enable and timeout ticks, always ready.
// An input word is taken in the idle state and planned in the next cycle;
// its results then leave one per cycle from the output register while the
// receiver is ready, the first loaded after the planning state. A good
// checksum word releases its buffered reply bytes ahead of its status,
// paced by the registered read port of the reply buffer. The next input
// word is taken as soon as the last result is loaded, even while that
// result still waits in the output register. When the receiver stalls,
// the result sequence stops and the input stays blocked until it resumes.
// Reset returns the core to idle, clears the counters and sums, restores
// the configuration defaults and empties the output register.
`default_nettype none

module mdb_master_transaction_core
    import mdb_mt_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in_word              i_in_word,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out_word                  o_out_word,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    mdb_mt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    mdb_mt_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

endmodule

`default_nettype wire

// File: rtl/core/mdb_mt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module mdb_mt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 36,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/mdb_mt_dp.sv
// Datapath: configuration, transaction state, reply buffer and output register.
`default_nettype none
`include "assert_macros.svh"

module mdb_mt_dp
    import mdb_mt_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_in_word              i_in_word,
    input  wire logic                  i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire t_cmd                  i_cmd,
    output t_sts                       o_sts,
    input  wire logic                  i_out_ready,
    output logic                       o_out_valid,
    output t_out_word                  o_out_word
);

    logic              r_master_en;
    logic [15:0]       r_timeout;
    logic [1:0]        r_phase, n_phase;
    logic [SENT_W-1:0] r_sent, n_sent;
    logic [7:0]        r_ssum, n_ssum;
    logic [RCNT_W-1:0] r_rcount, n_rcount;
    logic [7:0]        r_rsum, n_rsum;
    logic              r_heard, n_heard;
    logic [15:0]       r_timer, n_timer;

    logic [RCNT_W-1:0] r_nd, n_nd;
    t_out_word         r_t0, n_t0;
    t_out_word         r_t1, n_t1;
    logic              r_t0v, n_t0v;
    logic              r_t1v, n_t1v;
    logic [RAM_AW-1:0] r_idx;

    logic              r_out_valid;
    t_out_word         r_out, n_out;

    logic              word_v;
    logic [8:0]        word;
    logic [8:0]        sum_word;
    logic [7:0]        rx_v;
    logic [15:0]       timer_inc;
    logic              wr_en;
    logic [RAM_AW-1:0] rd_addr;
    logic [7:0]        rd_data;
    logic              ld_any;

    always_comb begin
        n_phase  = r_phase;
        n_sent   = r_sent;
        n_ssum   = r_ssum;
        n_rcount = r_rcount;
        n_rsum   = r_rsum;
        n_heard  = r_heard;
        n_timer  = r_timer;
        n_nd     = '0;
        n_t0     = '0;
        n_t1     = '0;
        n_t0v    = 1'b0;
        n_t1v    = 1'b0;
        word_v   = 1'b0;
        word     = '0;
        sum_word = '0;
        wr_en    = 1'b0;
        rx_v     = i_in_word.rx_word[7:0];
        timer_inc = (r_timer != TIMER_MAX) ? r_timer + 16'd1 : r_timer;
        if (i_cmd.process) begin
            unique case (i_in_word.action)
                ACT_FRAME: begin
                    if (!r_master_en) begin
                        n_phase = PH_IDLE;
                        n_t0    = f_status(ST_NOT_MASTER);
                        n_t0v   = 1'b1;
                    end else if (r_phase != PH_WAIT) begin
                        if (r_phase == PH_IDLE) begin
                            word_v  = 1'b1;
                            word    = {MODE_BIT, i_in_word.frame_byte};
                            n_sent  = SENT_W'(1);
                            n_ssum  = i_in_word.frame_byte;
                            n_phase = PH_SEND;
                        end else if (r_sent < SENT_W'(FRAME_BYTES)) begin
                            word_v = 1'b1;
                            word   = {1'b0, i_in_word.frame_byte};
                            n_sent = r_sent + SENT_W'(1);
                            n_ssum = r_ssum + i_in_word.frame_byte;
                        end
                        sum_word = {1'b0, n_ssum};
                        if (i_in_word.frame_last) begin
                            n_phase  = PH_WAIT;
                            n_rcount = '0;
                            n_rsum   = '0;
                            n_heard  = 1'b0;
                            n_timer  = '0;
                        end
                        n_t0  = word_v ? f_tx(word) : f_tx(sum_word);
                        n_t0v = word_v | i_in_word.frame_last;
                        n_t1  = f_tx(sum_word);
                        n_t1v = word_v & i_in_word.frame_last;
                    end
                end
                ACT_BUS: begin
                    if (r_phase == PH_WAIT) begin
                        n_timer = '0;
                        n_heard = 1'b1;
                        if (i_in_word.rx_word[8]) begin
                            n_phase = PH_IDLE;
                            n_t0v   = 1'b1;
                            if (r_rcount == '0 && rx_v == WORD_ACK) begin
                                n_t0 = f_status(ST_ACK);
                            end else if (r_rcount == '0 && rx_v == WORD_NAK) begin
                                n_t0 = f_status(ST_NAK);
                            end else if (r_rcount == '0 && rx_v == WORD_RET) begin
                                n_t0 = f_status(ST_RET);
                            end else if (rx_v == r_rsum) begin
                                n_nd  = r_rcount;
                                n_t0  = f_status(ST_DONE);
                                n_t1  = f_tx({MODE_BIT, WORD_ACK});
                                n_t1v = 1'b1;
                            end else begin
                                n_t0  = f_status(ST_CHECKSUM);
                                n_t1  = f_tx({MODE_BIT, WORD_NAK});
                                n_t1v = 1'b1;
                            end
                        end else if (r_rcount < RCNT_W'(REPLY_DEPTH)) begin
                            wr_en    = 1'b1;
                            n_rcount = r_rcount + RCNT_W'(1);
                            n_rsum   = r_rsum + rx_v;
                        end else begin
                            n_phase = PH_IDLE;
                            n_t0    = f_status(ST_OVERFLOW);
                            n_t0v   = 1'b1;
                        end
                    end
                end
                ACT_TICK: begin
                    if (r_phase == PH_WAIT) begin
                        n_timer = timer_inc;
                        if (timer_inc >= r_timeout) begin
                            n_phase = PH_IDLE;
                            if (!r_heard) begin
                                n_t0  = f_status(ST_TIMEOUT);
                                n_t0v = 1'b1;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_master_en <= 1'b0;
            r_timeout   <= TIMEOUT_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MASTER_ENABLE: r_master_en <= i_cfg_data[0];
                CFG_TIMEOUT_TICKS: r_timeout   <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_sent   <= '0;
            r_ssum   <= '0;
            r_rcount <= '0;
            r_rsum   <= '0;
            r_heard  <= 1'b0;
            r_timer  <= '0;
        end else begin
            r_phase  <= n_phase;
            r_sent   <= n_sent;
            r_ssum   <= n_ssum;
            r_rcount <= n_rcount;
            r_rsum   <= n_rsum;
            r_heard  <= n_heard;
            r_timer  <= n_timer;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.process) begin
            r_nd  <= n_nd;
            r_t0  <= n_t0;
            r_t1  <= n_t1;
            r_t0v <= n_t0v;
            r_t1v <= n_t1v;
            r_idx <= '0;
        end else if (i_cmd.ld_data) begin
            r_idx <= r_idx + RAM_AW'(1);
        end
    end

    assign rd_addr = i_cmd.rd_next ? r_idx + RAM_AW'(1) : r_idx;

    mdb_mt_ram #(
        .WIDTH (8),
        .DEPTH (REPLY_DEPTH)
    ) u_reply_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_rcount[RAM_AW-1:0]),
        .i_wr_data (rx_v),
        .i_rd_en   (i_cmd.rd),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign ld_any = i_cmd.ld_data | i_cmd.ld_tail0 | i_cmd.ld_tail1;

    always_comb begin
        n_out = r_out;
        if (i_cmd.ld_data) begin
            n_out = f_data(rd_data);
        end else if (i_cmd.ld_tail0) begin
            n_out      = r_t0;
            n_out.last = !r_t1v;
        end else if (i_cmd.ld_tail1) begin
            n_out      = r_t1;
            n_out.last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ld_any) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_word      = r_out;
    assign o_sts.slot_free = !r_out_valid | i_out_ready;
    assign o_sts.nd_zero   = (r_nd == '0);
    assign o_sts.idx_last  = (RCNT_W'(r_idx) + RCNT_W'(1) == r_nd);
    assign o_sts.tail0_v   = r_t0v;
    assign o_sts.tail1_v   = r_t1v;

    `ASSERT_IMPLIES(a_idx_in_range, i_cmd.ld_data, RCNT_W'(r_idx) < r_nd, "Read index past reply count.")
    `ASSERT_HOLDS(a_rcount_bound, r_rcount <= RCNT_W'(REPLY_DEPTH), "Reply count past buffer depth.")

endmodule

`default_nettype wire

// File: rtl/core/mdb_mt_ctrl.sv
// Controller: sequences item intake, reply buffer reads and result loads.
`default_nettype none
`include "assert_macros.svh"

module mdb_mt_ctrl
    import mdb_mt_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PLAN  = 3'd1;
    localparam logic [2:0] S_DATA  = 3'd2;
    localparam logic [2:0] S_TAIL0 = 3'd3;
    localparam logic [2:0] S_TAIL1 = 3'd4;

    logic [2:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.process = 1'b1;
                    n_state       = S_PLAN;
                end
            end
            S_PLAN: begin
                o_cmd.rd = 1'b1;
                if (!i_sts.nd_zero) begin
                    n_state = S_DATA;
                end else if (i_sts.tail0_v) begin
                    n_state = S_TAIL0;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DATA: begin
                if (i_sts.slot_free) begin
                    o_cmd.ld_data = 1'b1;
                    if (i_sts.idx_last) begin
                        n_state = S_TAIL0;
                    end else begin
                        o_cmd.rd      = 1'b1;
                        o_cmd.rd_next = 1'b1;
                    end
                end
            end
            S_TAIL0: begin
                if (i_sts.slot_free) begin
                    o_cmd.ld_tail0 = 1'b1;
                    n_state        = i_sts.tail1_v ? S_TAIL1 : S_IDLE;
                end
            end
            S_TAIL1: begin
                if (i_sts.slot_free) begin
                    o_cmd.ld_tail1 = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    `ASSERT_IMPLIES(a_load_needs_slot, o_cmd.ld_data || o_cmd.ld_tail0 || o_cmd.ld_tail1, i_sts.slot_free, "Result loaded into a full output register.")
    `ASSERT_HOLDS(a_single_load, ($onehot0({o_cmd.ld_data, o_cmd.ld_tail0, o_cmd.ld_tail1})), "More than one result loaded in a cycle.")
    `ASSERT_NEXT(a_data_after_plan, r_state == S_PLAN && !i_sts.nd_zero, r_state == S_DATA && !o_in_ready, "Buffered reply not drained after a good sum.")

endmodule

`default_nettype wire
